### src/ostg_pkg.sv
// Package for the one-shot timer group: item kinds, controller states,
// and the control struct handed to each order cell. No dependencies.
package ostg_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_TAIL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

### src/ostg_cell.sv
// One position of the running order: holds the slot id stored there.
// Depends on ostg_pkg for the control struct.
module ostg_cell import ostg_pkg::*; #(
    parameter int SLOT_BITS = 4
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [SLOT_BITS-1:0] i_from_next,
    input  logic [SLOT_BITS-1:0] i_load_slot,
    output logic [SLOT_BITS-1:0] o_slot
);

    logic [SLOT_BITS-1:0] r_slot;
    logic [SLOT_BITS-1:0] n_slot;

    // Load wins over shift: the tail cell takes the re-queued slot
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.load) begin
            n_slot = i_load_slot;
        end else if (i_ctl.shift) begin
            n_slot = i_from_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

### src/one_shot_timer_group.sv
// Top level of the one-shot timer group: order chain of ostg_cell and the
// remaining-count memory with its sequencer. Depends on ostg_pkg, ostg_cell.
//
//   channel | direction | handshake               | payload
//   input   | in        | i_in_valid / o_in_ready | i_kind i_slot i_duration i_now
//   output  | out       | o_out_valid/ i_out_ready| o_fired o_fired_slot o_next_expiry
//           |           |                         | o_armed o_ticks_left
//
// For each item the order chain rotates once through the N armed slots: each
// entry passes an S_READ and then an S_STEP state, since the read port of the
// remaining-count memory is registered. Reset clears the order count, last time
// and the per-slot valid bits; unwritten slots read as zero. A stalled result
// is held in the output register while the next item is taken.
module one_shot_timer_group import ostg_pkg::*; #(
    parameter int TIMER_SLOTS = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_duration,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fired,
    output logic [3:0]  o_fired_slot,
    output logic [31:0] o_next_expiry,
    output logic        o_armed,
    output logic [31:0] o_ticks_left
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int XS = SW + 4;
    localparam int XW = TICK_BITS + 32;

    t_state               r_state, n_state;
    t_kind                r_kind;
    logic [SW-1:0]        r_sidx;
    logic                 r_inr;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_steps;
    logic [TICK_BITS-1:0] r_last;
    logic [TICK_BITS-1:0] r_delta;
    logic [TICK_BITS-1:0] r_next;
    logic                 r_done;
    logic                 r_fired;
    logic [SW-1:0]        r_fslot;
    logic                 r_armed;

    logic [TICK_BITS-1:0] r_mem [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_vld;
    logic [TICK_BITS-1:0] r_rdata;
    logic                 r_rvld;

    logic                 r_ovalid;
    logic                 r_o_fired;
    logic [3:0]           r_o_fslot;
    logic [31:0]          r_o_next;
    logic                 r_o_armed;
    logic [31:0]          r_o_left;

    logic                 in_acc;
    logic [XS-1:0]        slot_x;
    logic                 in_inr;
    logic [SW-1:0]        in_sidx;
    logic [XW-1:0]        dur_x, now_x;
    logic [TICK_BITS-1:0] dur_m, now_m;

    logic [SW-1:0]        cell_slot [TIMER_SLOTS];
    logic [SW-1:0]        head;
    logic [TICK_BITS-1:0] rem;
    logic                 rem_lt;
    logic [TICK_BITS-1:0] rem_diff;
    logic                 is_run, match, keep, do_fire, append;
    logic                 st_read, st_step, st_tail, st_fin;
    logic                 fin_go;
    logic                 ld_go;
    logic [CW-1:0]        ld_idx;
    logic [SW-1:0]        ld_val;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr, rd_addr;
    logic [TICK_BITS-1:0] wr_data;
    logic [XS-1:0]        fslot_x;
    logic [XW-1:0]        next_x, left_x;

    // Decode the incoming item
    assign slot_x  = XS'(i_slot);
    assign in_inr  = slot_x < XS'(TIMER_SLOTS);
    assign in_sidx = slot_x[SW-1:0];
    assign dur_x   = XW'(i_duration);
    assign now_x   = XW'(i_now);
    assign dur_m   = dur_x[TICK_BITS-1:0];
    assign now_m   = now_x[TICK_BITS-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = (r_count != '0) ? S_READ : S_TAIL;
            S_READ: n_state = S_STEP;
            S_STEP: n_state = (r_steps == CW'(1)) ? S_TAIL : S_READ;
            S_TAIL: n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State decode
    always_comb begin
        o_in_ready = 1'b0;
        st_read    = 1'b0;
        st_step    = 1'b0;
        st_tail    = 1'b0;
        st_fin     = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = i_rst_n;
            S_READ:  st_read    = 1'b1;
            S_STEP:  st_step    = 1'b1;
            S_TAIL:  st_tail    = 1'b1;
            S_FIN:   st_fin     = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;
    assign fin_go = st_fin && (!r_ovalid || i_out_ready);

    // Examine the head of the order
    assign head     = cell_slot[0];
    assign rem      = r_rvld ? r_rdata : '0;
    assign rem_lt   = r_delta < rem;
    assign rem_diff = rem - r_delta;
    assign is_run   = (r_kind == KIND_RUN);
    assign match    = (head == r_sidx);
    assign do_fire  = is_run && !rem_lt && !r_done;

    always_comb begin
        case (r_kind) inside
            KIND_START, KIND_STOP: keep = !(r_inr && match);
            KIND_RUN:              keep = !do_fire;
            default:               keep = 1'b1;
        endcase
    end

    assign append = (r_kind == KIND_START) && r_inr && (r_count < CW'(TIMER_SLOTS));
    assign ld_go  = (st_step && keep) || (st_tail && append);
    assign ld_idx = st_step ? (r_count - CW'(1)) : r_count;
    assign ld_val = st_step ? head : r_sidx;

    // Order chain
    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        t_cell_ctl            ctl;
        logic [SW-1:0]        from_next;
        assign ctl.shift = st_step;
        assign ctl.load  = ld_go && (ld_idx == CW'(g));
        if (g < TIMER_SLOTS - 1) begin : g_mid
            assign from_next = cell_slot[g+1];
        end else begin : g_end
            assign from_next = '0;
        end
        ostg_cell #(.SLOT_BITS(SW)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_from_next (from_next),
            .i_load_slot (ld_val),
            .o_slot      (cell_slot[g])
        );
    end

    // Remaining-count memory ports
    assign wr_en   = (in_acc && (t_kind'(i_kind) == KIND_START) && in_inr) || (st_step && is_run);
    assign wr_addr = in_acc ? in_sidx : head;
    assign wr_data = in_acc ? dur_m : (rem_lt ? rem_diff : '0);
    assign rd_addr = st_read ? head : r_sidx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Valid bits stand in for the all-zero reset of the memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && (t_kind'(i_kind) == KIND_RUN)) begin
                r_last <= now_m;
            end
            if (st_step && !keep) begin
                r_count <= r_count - CW'(1);
            end else if (st_tail && append) begin
                r_count <= r_count + CW'(1);
            end
            if (fin_go) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= t_kind'(i_kind);
            r_sidx  <= in_sidx;
            r_inr   <= in_inr;
            r_steps <= r_count;
            r_delta <= now_m - r_last;
            r_next  <= '1;
            r_done  <= 1'b0;
            r_fired <= 1'b0;
            r_fslot <= '0;
            r_armed <= 1'b0;
        end else if (st_step) begin
            r_steps <= r_steps - CW'(1);
            if (is_run) begin
                if (rem_lt) begin
                    if (rem_diff < r_next) r_next <= rem_diff;
                end else if (r_done) begin
                    r_next <= '0;
                end else begin
                    r_done  <= 1'b1;
                    r_fired <= 1'b1;
                    r_fslot <= head;
                end
            end else if ((r_kind == KIND_QUERY) && match) begin
                r_armed <= 1'b1;
            end
        end
    end

    // Output register
    assign fslot_x = XS'(r_fslot);
    assign next_x  = XW'(r_next);
    assign left_x  = XW'(rem);

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_o_fired <= is_run && r_fired;
            r_o_fslot <= (is_run && r_fired) ? fslot_x[3:0] : 4'd0;
            r_o_next  <= is_run ? next_x[31:0] : 32'd0;
            r_o_armed <= (r_kind == KIND_QUERY) && r_inr && r_armed;
            r_o_left  <= ((r_kind == KIND_QUERY) && r_inr) ? left_x[31:0] : 32'd0;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_fired       = r_o_fired;
    assign o_fired_slot  = r_o_fslot;
    assign o_next_expiry = r_o_next;
    assign o_armed       = r_o_armed;
    assign o_ticks_left  = r_o_left;

endmodule
